// File: design/wtsp_pkg.sv
// World-to-screen projection: shared types and fixed widths.
// No dependencies.
`default_nettype none

package wtsp_pkg;

   localparam int COEF_W    = 32;
   localparam int PROD_W    = 64;
   localparam int SUM_W     = 66;
   localparam int CLIP_W    = 50;
   localparam int NUM_W     = 66;
   localparam int MAG_W     = 65;
   localparam int DEN_W     = 50;
   localparam int REM_W     = 50;
   localparam int QUO_W     = 33;
   localparam int SAT_SHIFT = 17;
   localparam int FRAC_W    = 16;
   localparam int DIV_STEPS = 33;
   localparam int REG_COUNT = 8;
   localparam int REG_W     = 64;
   localparam int INDEX_W   = 3;
   localparam int ROWS      = 3;
   localparam int COLS      = 3;

   typedef struct packed {
      logic signed [31:0] tag;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] tag_out;
      logic signed [31:0] screen_x;
      logic signed [31:0] screen_y;
      logic signed [31:0] depth;
      logic               projected;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0]       tag;
      logic signed [CLIP_W-1:0] cx;
      logic signed [CLIP_W-1:0] cy;
      logic signed [CLIP_W-1:0] cw;
   } clip_type;

   typedef logic [REG_COUNT-1:0][REG_W-1:0] regs_type;

   // index 7 down to index 0
   localparam regs_type REG_RESET = {
      64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
      64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
   };

endpackage

`default_nettype wire

// File: design/wtsp_fifo.sv
// Two-entry queue used between pipeline parts and for results.
// No package dependencies; item type is a parameter.
`default_nettype none

module wtsp_fifo #(
   parameter type item_type = logic
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type din,
   input  wire logic     pop,
   output item_type      dout,
   output logic          full,
   output logic          empty
);

   item_type   entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign dout  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: design/wtsp_front.sv
// Front part: matrix rows x, y, w times the point, rounded to Q16.16.
// Uses wtsp_pkg.
`default_nettype none

module wtsp_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire wtsp_pkg::regs_type regs,
   input  wire logic               in_valid,
   input  wire wtsp_pkg::req_type  in_item,
   output logic                    in_ready,
   input  wire logic               out_full,
   output logic                    out_valid,
   output wtsp_pkg::clip_type      out_item
);

   localparam int PW = wtsp_pkg::PROD_W;
   localparam int SW = wtsp_pkg::SUM_W;

   logic                 en;
   logic                 v1_ff, v2_ff, v3_ff;
   logic signed [31:0]   tag1_ff, tag2_ff;
   logic signed [PW-1:0] prod_ff [wtsp_pkg::ROWS][wtsp_pkg::COLS];
   logic signed [PW-1:0] prod_in [wtsp_pkg::ROWS][wtsp_pkg::COLS];
   logic signed [SW-1:0] pa_ff [wtsp_pkg::ROWS];
   logic signed [SW-1:0] pb_ff [wtsp_pkg::ROWS];
   logic signed [SW-1:0] pa_in [wtsp_pkg::ROWS];
   logic signed [SW-1:0] pb_in [wtsp_pkg::ROWS];
   logic signed [SW-1:0] sum   [wtsp_pkg::ROWS];
   wtsp_pkg::clip_type   clip_ff, clip_in;

   function automatic logic signed [31:0] coef(wtsp_pkg::regs_type r, int row, int col);
      logic [wtsp_pkg::REG_W-1:0] word;
      word = r[2 * row + col / 2];
      return (col % 2 == 0) ? $signed(word[31:0]) : $signed(word[63:32]);
   endfunction

   // rows used: x, y and w
   function automatic int row_of(int i);
      return (i == 2) ? 3 : i;
   endfunction

   assign en        = !v3_ff || !out_full;
   assign in_ready  = en;
   assign out_valid = v3_ff;
   assign out_item  = clip_ff;

   always_comb begin
      for (int i = 0; i < wtsp_pkg::ROWS; i++) begin
         prod_in[i][0] = coef(regs, row_of(i), 0) * in_item.pos_x;
         prod_in[i][1] = coef(regs, row_of(i), 1) * in_item.pos_y;
         prod_in[i][2] = coef(regs, row_of(i), 2) * in_item.pos_z;
         pa_in[i] = SW'(prod_ff[i][0]) + SW'(prod_ff[i][1]);
         pb_in[i] = SW'(prod_ff[i][2])
                  + (SW'(coef(regs, row_of(i), 3)) <<< wtsp_pkg::FRAC_W)
                  + SW'(32'sh8000);
         sum[i]   = pa_ff[i] + pb_ff[i];
      end
      clip_in.tag = tag2_ff;
      clip_in.cx  = sum[0][SW-1:wtsp_pkg::FRAC_W];
      clip_in.cy  = sum[1][SW-1:wtsp_pkg::FRAC_W];
      clip_in.cw  = sum[2][SW-1:wtsp_pkg::FRAC_W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         tag1_ff <= in_item.tag;
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         tag2_ff <= tag1_ff;
         clip_ff <= clip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

endmodule

`default_nettype wire

// File: design/wtsp_back.sv
// Back part: screen mapping, pipelined restoring division, saturation.
// Uses wtsp_pkg.
`default_nettype none

module wtsp_back #(
   parameter int SCREEN_WIDTH  = 1920,
   parameter int SCREEN_HEIGHT = 1080
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire wtsp_pkg::clip_type in_item,
   output logic                    in_pop,
   input  wire logic               out_full,
   output logic                    out_valid,
   output wtsp_pkg::rsp_type       out_item
);

   localparam int NW = wtsp_pkg::NUM_W;
   localparam int CW = wtsp_pkg::CLIP_W;
   localparam int MW = wtsp_pkg::MAG_W;
   localparam int DW = wtsp_pkg::DEN_W;
   localparam int RW = wtsp_pkg::REM_W;
   localparam int QW = wtsp_pkg::QUO_W;
   localparam int SS = wtsp_pkg::SAT_SHIFT;
   localparam int NS = wtsp_pkg::DIV_STEPS;
   localparam logic signed [NW-1:0] SCALE_X = NW'(SCREEN_WIDTH);
   localparam logic signed [NW-1:0] SCALE_Y = NW'(SCREEN_HEIGHT);
   localparam logic signed [31:0]   S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0]   S32_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic                 valid;
      logic signed [31:0]   tag;
      logic signed [NW-1:0] num_x;
      logic signed [NW-1:0] num_y;
      logic signed [CW-1:0] cw;
   } stage_a_type;

   typedef struct packed {
      logic               valid;
      logic signed [31:0] tag;
      logic [MW-1:0]      n_x;
      logic [MW-1:0]      n_y;
      logic [DW-1:0]      den;
      logic               neg_x;
      logic               neg_y;
      logic               zero;
      logic signed [31:0] depth;
   } stage_b_type;

   typedef struct packed {
      logic               valid;
      logic signed [31:0] tag;
      logic [RW-1:0]      rem_x;
      logic [RW-1:0]      rem_y;
      logic [QW-1:0]      low_x;
      logic [QW-1:0]      low_y;
      logic [QW-1:0]      quo_x;
      logic [QW-1:0]      quo_y;
      logic               sat_x;
      logic               sat_y;
      logic [DW-1:0]      den;
      logic               neg_x;
      logic               neg_y;
      logic               zero;
      logic signed [31:0] depth;
   } div_type;

   logic              en;
   stage_a_type       a_ff, a_in;
   stage_b_type       b_ff, b_in;
   div_type           div_ff [NS+1];
   div_type           div_in [NS+1];
   logic              fin_valid_ff;
   wtsp_pkg::rsp_type fin_ff, fin_in;
   logic signed [CW:0] sum_x, sum_y;

   function automatic logic [RW+QW+QW-1:0] step(logic [RW-1:0] rem, logic [QW-1:0] low,
                                                logic [QW-1:0] quo, logic [DW-1:0] den);
      logic [RW:0] t;
      logic        ge;
      logic [RW-1:0] r;
      t  = {rem, low[QW-1]};
      ge = (t >= (RW+1)'(den));
      r  = ge ? RW'(t - (RW+1)'(den)) : RW'(t);
      return {r, low << 1, quo[QW-2:0], ge};
   endfunction

   function automatic logic signed [31:0] finish(logic sat, logic neg, logic [QW-1:0] quo);
      logic [QW:0]   rounded;
      logic [QW-1:0] mag;
      logic [QW-1:0] nmag;
      rounded = ((QW+1)'(quo) + (QW+1)'(1)) >> 1;
      mag     = rounded[QW-1:0];
      nmag    = -mag;
      if (sat) begin
         return neg ? S32_MIN : S32_MAX;
      end else if (neg) begin
         return (mag > QW'(33'h0_8000_0000)) ? S32_MIN : $signed(nmag[31:0]);
      end else begin
         return (mag > QW'(33'h0_7fff_ffff)) ? S32_MAX : $signed(mag[31:0]);
      end
   endfunction

   assign en        = !fin_valid_ff || !out_full;
   assign in_pop    = en && in_valid;
   assign out_valid = fin_valid_ff;
   assign out_item  = fin_ff;

   always_comb begin
      sum_x       = (CW+1)'(in_item.cx) + (CW+1)'(in_item.cw);
      sum_y       = (CW+1)'(in_item.cw) - (CW+1)'(in_item.cy);
      a_in.valid  = in_valid;
      a_in.tag    = in_item.tag;
      a_in.num_x  = NW'(sum_x) * SCALE_X;
      a_in.num_y  = NW'(sum_y) * SCALE_Y;
      a_in.cw     = in_item.cw;

      b_in.valid  = a_ff.valid;
      b_in.tag    = a_ff.tag;
      b_in.n_x    = a_ff.num_x[NW-1] ? MW'(-a_ff.num_x) : MW'(a_ff.num_x);
      b_in.n_y    = a_ff.num_y[NW-1] ? MW'(-a_ff.num_y) : MW'(a_ff.num_y);
      b_in.den    = a_ff.cw[CW-1] ? DW'(-a_ff.cw) : DW'(a_ff.cw);
      b_in.neg_x  = a_ff.num_x[NW-1] ^ a_ff.cw[CW-1];
      b_in.neg_y  = a_ff.num_y[NW-1] ^ a_ff.cw[CW-1];
      b_in.zero   = (a_ff.cw == '0);
      if (a_ff.cw > CW'(S32_MAX)) begin
         b_in.depth = S32_MAX;
      end else if (a_ff.cw < CW'(S32_MIN)) begin
         b_in.depth = S32_MIN;
      end else begin
         b_in.depth = a_ff.cw[31:0];
      end

      div_in[0].valid = b_ff.valid;
      div_in[0].tag   = b_ff.tag;
      div_in[0].rem_x = RW'(b_ff.n_x >> SS);
      div_in[0].rem_y = RW'(b_ff.n_y >> SS);
      div_in[0].low_x = QW'({b_ff.n_x[SS-1:0], 16'b0});
      div_in[0].low_y = QW'({b_ff.n_y[SS-1:0], 16'b0});
      div_in[0].quo_x = '0;
      div_in[0].quo_y = '0;
      div_in[0].sat_x = ({2'b0, b_ff.n_x} >= {b_ff.den, SS'(0)});
      div_in[0].sat_y = ({2'b0, b_ff.n_y} >= {b_ff.den, SS'(0)});
      div_in[0].den   = b_ff.den;
      div_in[0].neg_x = b_ff.neg_x;
      div_in[0].neg_y = b_ff.neg_y;
      div_in[0].zero  = b_ff.zero;
      div_in[0].depth = b_ff.depth;

      for (int k = 1; k <= NS; k++) begin
         div_in[k] = div_ff[k-1];
         {div_in[k].rem_x, div_in[k].low_x, div_in[k].quo_x} =
            step(div_ff[k-1].rem_x, div_ff[k-1].low_x, div_ff[k-1].quo_x, div_ff[k-1].den);
         {div_in[k].rem_y, div_in[k].low_y, div_in[k].quo_y} =
            step(div_ff[k-1].rem_y, div_ff[k-1].low_y, div_ff[k-1].quo_y, div_ff[k-1].den);
      end

      fin_in.tag_out   = div_ff[NS].tag;
      fin_in.projected = !div_ff[NS].zero;
      if (div_ff[NS].zero) begin
         fin_in.screen_x = '0;
         fin_in.screen_y = '0;
         fin_in.depth    = '0;
      end else begin
         fin_in.screen_x = finish(div_ff[NS].sat_x, div_ff[NS].neg_x, div_ff[NS].quo_x);
         fin_in.screen_y = finish(div_ff[NS].sat_y, div_ff[NS].neg_y, div_ff[NS].quo_y);
         fin_in.depth    = div_ff[NS].depth;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid   <= 1'b0;
         b_ff.valid   <= 1'b0;
         fin_valid_ff <= 1'b0;
         for (int k = 0; k <= NS; k++) begin
            div_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         a_ff         <= a_in;
         b_ff         <= b_in;
         div_ff       <= div_in;
         fin_valid_ff <= div_ff[NS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_ff <= fin_in;
      end
   end

endmodule

`default_nettype wire

// File: design/world_to_screen_projection.sv
// Throughput: one request per cycle while no full queue stalls the pipeline.
// The pipelined divider sets the pipeline depth.
// Reset: synchronous, active high; clears the queues and loads the matrix defaults.
// Top level: config registers, front part, queue, back part, result queue.
// Uses wtsp_pkg, wtsp_fifo, wtsp_front, wtsp_back.
`default_nettype none

module world_to_screen_projection #(
   parameter int SCREEN_WIDTH  = 1920,
   parameter int SCREEN_HEIGHT = 1080
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   input  wire wtsp_pkg::req_type               req_item,
   output logic                                 req_full,
   output logic                                 rsp_empty,
   output wtsp_pkg::rsp_type                    rsp_item,
   input  wire logic                            rsp_pop,
   input  wire logic                            csr_we,
   input  wire logic [wtsp_pkg::INDEX_W-1:0]    csr_index,
   input  wire logic [wtsp_pkg::REG_W-1:0]      csr_wdata
);

   wtsp_pkg::regs_type regs_ff;
   logic               front_ready;
   logic               mid_push, mid_full, mid_empty, mid_pop;
   wtsp_pkg::clip_type mid_din, mid_dout;
   logic               out_push, out_full;
   wtsp_pkg::rsp_type  out_din;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= wtsp_pkg::REG_RESET;
      end else if (csr_we) begin
         regs_ff[csr_index] <= csr_wdata;
      end
   end

   assign req_full = !front_ready;

   wtsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .regs      (regs_ff),
      .in_valid  (req_push),
      .in_item   (req_item),
      .in_ready  (front_ready),
      .out_full  (mid_full),
      .out_valid (mid_push),
      .out_item  (mid_din)
   );

   wtsp_fifo #(.item_type(wtsp_pkg::clip_type)) u_mid_q (
      .clock (clock),
      .reset (reset),
      .push  (mid_push && !mid_full),
      .din   (mid_din),
      .pop   (mid_pop),
      .dout  (mid_dout),
      .full  (mid_full),
      .empty (mid_empty)
   );

   wtsp_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!mid_empty),
      .in_item   (mid_dout),
      .in_pop    (mid_pop),
      .out_full  (out_full),
      .out_valid (out_push),
      .out_item  (out_din)
   );

   wtsp_fifo #(.item_type(wtsp_pkg::rsp_type)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push && !out_full),
      .din   (out_din),
      .pop   (rsp_pop && !rsp_empty),
      .dout  (rsp_item),
      .full  (out_full),
      .empty (rsp_empty)
   );

`ifndef SYNTH
   a_unprojected_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_item.projected) |->
         (rsp_item.screen_x == 0 && rsp_item.screen_y == 0 && rsp_item.depth == 0))
      else $error("unprojected result carries nonzero fields");

   a_projected_depth: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.projected) |-> (rsp_item.depth != 0))
      else $error("projected result with zero depth");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !mid_push))
      else $error("queues not cleared by reset");

   a_mid_pop_valid: assert property (@(posedge clock) disable iff (reset)
      mid_pop |-> !mid_empty)
      else $error("back part popped an empty queue");
`endif

endmodule

`default_nettype wire
